>>> src/btbf_pkg.sv
// Shared constants and types of the boundary-tag best-fit allocator.
`default_nettype none

package btbf_pkg;

    localparam int ARENA_WORDS_DEF = 128;

    localparam int REQ_W  = 9;
    localparam int OFF_W  = 7;
    localparam int ST_W   = 2;
    localparam int NEED_W = 8;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

`default_nettype wire

>>> src/btbf_mem.sv
// Header word memory of the arena: one write port, one read port with registered data.
`default_nettype none

module btbf_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read, so the sequencer may look at it later.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/btbf_alu.sv
// Shared adder/subtractor used by the allocator sequencer for every address and size step.
`default_nettype none

module btbf_alu #(
    parameter int XW = 10
) (
    input  wire btbf_pkg::alu_op_t op,
    input  wire logic [XW-1:0]     a,
    input  wire logic [XW-1:0]     b,
    output logic      [XW-1:0]     res,
    output logic                   carry
);

    logic [XW:0] sum;

    always_comb
    begin
        case (op)
            btbf_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            btbf_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
            default:           sum = '0;
        endcase
    end

    // On a subtract the carry bit is the borrow, set when a is below b.
    assign res   = sum[XW-1:0];
    assign carry = sum[XW];

endmodule

`default_nettype wire

>>> src/boundary_tag_best_fit_allocator.sv
// Top level of the boundary-tag best-fit allocator: command sequencer around the arena memory.
//
// A command is taken when start is high and busy is low; its single result is shown with
// done high for exactly one cycle, and cannot be held off. An allocate sizes the request,
// walks the block list from word 0 with one header read per block (a free block also gets
// a fit test and a best-fit compare on the shared adder), then writes the headers and the
// granted offset. A free walks to its block, then does the neighbor checks and the two
// header writes. A free of offset zero or past the arena is answered in the cycle after
// it is taken; any other bad address is answered as soon as the walk reaches the block
// where it fails. After reset, with busy high, the block writes all ARENA_SIZE words (arena
// words, rounded up to even) as one free block, zero inside, before its first command.
`default_nettype none

module boundary_tag_best_fit_allocator #(
    parameter int ARENA_WORDS = btbf_pkg::ARENA_WORDS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       command,
    input  wire logic [btbf_pkg::REQ_W-1:0] request_bytes,
    input  wire logic [btbf_pkg::OFF_W-1:0] free_offset,
    output logic                            done,
    output logic      [btbf_pkg::ST_W-1:0]  status,
    output logic      [btbf_pkg::OFF_W-1:0] alloc_offset
);

    localparam int ARENA_SIZE = (ARENA_WORDS + 1) / 2 * 2;
    localparam int AW         = $clog2(ARENA_SIZE);
    localparam int DW         = $clog2(ARENA_SIZE + 1);
    localparam int XW         = (DW + 1 > 10) ? DW + 1 : 10;

    localparam logic [XW-1:0] SIZE_X   = XW'(ARENA_SIZE);
    localparam logic [XW-1:0] ONE_X    = XW'(1);
    localparam logic [XW-1:0] THREE_X  = XW'(3);
    localparam logic [AW-1:0] LAST_A   = AW'(ARENA_SIZE - 1);
    localparam logic [DW-1:0] SIZE_D   = DW'(ARENA_SIZE);

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_NEED,
        S_WALK,
        S_DIFF,
        S_CMP,
        S_AFIN,
        S_AW1,
        S_AW2,
        S_AW3,
        S_ARES,
        S_FWALK,
        S_FNX,
        S_FNXD,
        S_FNXA,
        S_FPV,
        S_FPVD,
        S_FPVA,
        S_FWR,
        S_FWR2
    } state_t;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 clr_reg, clr_next;
    logic                          done_reg, done_next;
    logic [btbf_pkg::ST_W-1:0]     status_reg, status_next;
    logic [btbf_pkg::OFF_W-1:0]    offset_reg, offset_next;
    logic                          found_reg, found_next;
    logic [btbf_pkg::NEED_W-1:0]   need_reg, need_next;
    logic [XW-1:0]                 cur_reg, cur_next;
    logic [XW-1:0]                 nxt_reg, nxt_next;
    logic [XW-1:0]                 s_reg, s_next;
    logic [XW-1:0]                 diff_reg, diff_next;
    logic [XW-1:0]                 best_reg, best_next;
    logic [XW-1:0]                 bdiff_reg, bdiff_next;
    logic [XW-1:0]                 e_reg, e_next;
    logic [XW-1:0]                 h_reg, h_next;
    logic [XW-1:0]                 size_reg, size_next;

    btbf_pkg::alu_op_t             alu_op;
    logic [XW-1:0]                 alu_a;
    logic [XW-1:0]                 alu_b;
    logic [XW-1:0]                 alu_res;
    logic                          alu_carry;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [DW-1:0]                 mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    logic [DW-1:0]                 mem_rdata;

    logic [XW-1:0]                 hdr_size;
    logic                          hdr_used;
    logic [XW-1:0]                 hdr_word;
    logic [XW-1:0]                 need_x;
    logic [XW-1:0]                 off_x;

    assign hdr_size = XW'({mem_rdata[DW-1:1], 1'b0});
    assign hdr_used = mem_rdata[0];
    assign hdr_word = XW'(mem_rdata);
    assign need_x   = XW'(need_reg);
    assign off_x    = XW'(free_offset);

    btbf_mem #(
        .DEPTH (ARENA_SIZE),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    btbf_alu #(
        .XW (XW)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .carry (alu_carry)
    );

    // Operand selection for the shared adder, one operation per state.
    always_comb
    begin
        alu_op = btbf_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            S_CLR:
            begin
                alu_a = XW'(clr_reg);
                alu_b = ONE_X;
            end
            S_IDLE:
            begin
                if (command == btbf_pkg::CMD_FREE)
                begin
                    alu_op = btbf_pkg::ALU_SUB;
                    alu_a  = off_x;
                    alu_b  = ONE_X;
                end
                else
                begin
                    alu_a = XW'(request_bytes);
                    alu_b = THREE_X;
                end
            end
            S_NEED:
            begin
                alu_a = need_x;
                alu_b = THREE_X;
            end
            S_WALK, S_FWALK:
            begin
                alu_a = cur_reg;
                alu_b = hdr_size;
            end
            S_DIFF:
            begin
                alu_op = btbf_pkg::ALU_SUB;
                alu_a  = s_reg;
                alu_b  = need_x;
            end
            S_CMP:
            begin
                alu_op = btbf_pkg::ALU_SUB;
                alu_a  = diff_reg;
                alu_b  = bdiff_reg;
            end
            S_AFIN:
            begin
                alu_a = best_reg;
                alu_b = need_x;
            end
            S_AW1, S_AW3, S_FWR2:
            begin
                alu_op = btbf_pkg::ALU_SUB;
                alu_a  = e_reg;
                alu_b  = ONE_X;
            end
            S_AW2:
            begin
                alu_a = e_reg;
                alu_b = bdiff_reg;
            end
            S_ARES:
            begin
                alu_a = best_reg;
                alu_b = ONE_X;
            end
            S_FNX:
            begin
                alu_a = h_reg;
                alu_b = size_reg;
            end
            S_FNXD:
            begin
                alu_a = nxt_reg;
                alu_b = hdr_size;
            end
            S_FNXA, S_FPVA:
            begin
                alu_a = size_reg;
                alu_b = s_reg;
            end
            S_FPV:
            begin
                alu_op = btbf_pkg::ALU_SUB;
                alu_a  = h_reg;
                alu_b  = ONE_X;
            end
            S_FPVD:
            begin
                alu_op = btbf_pkg::ALU_SUB;
                alu_a  = h_reg;
                alu_b  = hdr_word;
            end
            S_FWR:
            begin
                alu_a = cur_reg;
                alu_b = size_reg;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // Sequencer: next state, memory accesses and result.
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        offset_next = offset_reg;
        found_next  = found_reg;
        need_next   = need_reg;
        cur_next    = cur_reg;
        nxt_next    = nxt_reg;
        s_next      = s_reg;
        diff_next   = diff_reg;
        best_next   = best_reg;
        bdiff_next  = bdiff_reg;
        e_next      = e_reg;
        h_next      = h_reg;
        size_next   = size_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = ((clr_reg == '0) || (clr_reg == LAST_A)) ? SIZE_D : '0;
                clr_next  = alu_res[AW-1:0];
                if (clr_reg == LAST_A)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == btbf_pkg::CMD_FREE)
                    begin
                        // Offset zero borrows; offsets past the arena are rejected too.
                        if (alu_carry || (off_x > SIZE_X))
                        begin
                            done_next   = 1'b1;
                            status_next = btbf_pkg::ST_BAD_FREE;
                            offset_next = '0;
                        end
                        else
                        begin
                            h_next     = alu_res;
                            cur_next   = '0;
                            mem_re     = 1'b1;
                            state_next = S_FWALK;
                        end
                    end
                    else
                    begin
                        need_next  = alu_res[btbf_pkg::NEED_W+1:2];
                        state_next = S_NEED;
                    end
                end
            end
            S_NEED:
            begin
                need_next  = {alu_res[btbf_pkg::NEED_W-1:1], 1'b0};
                cur_next   = '0;
                found_next = 1'b0;
                mem_re     = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if ((hdr_size == '0) || (alu_res > SIZE_X))
                begin
                    state_next = S_AFIN;
                end
                else if (hdr_used)
                begin
                    cur_next = alu_res;
                    if (alu_res >= SIZE_X)
                    begin
                        state_next = S_AFIN;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = alu_res[AW-1:0];
                    end
                end
                else
                begin
                    s_next     = hdr_size;
                    nxt_next   = alu_res;
                    state_next = S_DIFF;
                end
            end
            S_DIFF, S_CMP:
            begin
                if ((state_reg == S_DIFF) && !alu_carry && !found_reg)
                begin
                    found_next = 1'b1;
                    best_next  = cur_reg;
                    bdiff_next = alu_res;
                end
                else if ((state_reg == S_CMP) && alu_carry)
                begin
                    best_next  = cur_reg;
                    bdiff_next = diff_reg;
                end

                if ((state_reg == S_DIFF) && !alu_carry && found_reg)
                begin
                    diff_next  = alu_res;
                    state_next = S_CMP;
                end
                else
                begin
                    cur_next = nxt_reg;
                    if (nxt_reg >= SIZE_X)
                    begin
                        state_next = S_AFIN;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = nxt_reg[AW-1:0];
                        state_next = S_WALK;
                    end
                end
            end
            S_AFIN:
            begin
                if (!found_reg)
                begin
                    done_next   = 1'b1;
                    status_next = btbf_pkg::ST_NO_FIT;
                    offset_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = best_reg[AW-1:0];
                    mem_wdata  = {need_x[DW-1:1], 1'b1};
                    e_next     = alu_res;
                    state_next = S_AW1;
                end
            end
            S_AW1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = alu_res[AW-1:0];
                mem_wdata  = {need_x[DW-1:1], 1'b1};
                state_next = (bdiff_reg == '0) ? S_ARES : S_AW2;
            end
            S_AW2:
            begin
                // The split-off remainder becomes a free block right after the grant.
                mem_we     = 1'b1;
                mem_waddr  = e_reg[AW-1:0];
                mem_wdata  = bdiff_reg[DW-1:0];
                e_next     = alu_res;
                state_next = S_AW3;
            end
            S_AW3:
            begin
                mem_we     = 1'b1;
                mem_waddr  = alu_res[AW-1:0];
                mem_wdata  = bdiff_reg[DW-1:0];
                state_next = S_ARES;
            end
            S_ARES:
            begin
                done_next   = 1'b1;
                status_next = btbf_pkg::ST_OK;
                offset_next = alu_res[btbf_pkg::OFF_W-1:0];
                state_next  = S_IDLE;
            end
            S_FWALK:
            begin
                if ((hdr_size == '0) || (alu_res > SIZE_X) ||
                    ((cur_reg == h_reg) && !hdr_used) ||
                    ((cur_reg != h_reg) && ((alu_res >= SIZE_X) || (alu_res > h_reg))))
                begin
                    done_next   = 1'b1;
                    status_next = btbf_pkg::ST_BAD_FREE;
                    offset_next = '0;
                    state_next  = S_IDLE;
                end
                else if (cur_reg == h_reg)
                begin
                    size_next  = hdr_size;
                    state_next = S_FNX;
                end
                else
                begin
                    cur_next  = alu_res;
                    mem_re    = 1'b1;
                    mem_raddr = alu_res[AW-1:0];
                end
            end
            S_FNX:
            begin
                cur_next = h_reg;
                nxt_next = alu_res;
                if (alu_res < SIZE_X)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = alu_res[AW-1:0];
                    state_next = S_FNXD;
                end
                else
                begin
                    state_next = S_FPV;
                end
            end
            S_FNXD:
            begin
                if (!hdr_used && (hdr_size != '0) && (alu_res <= SIZE_X))
                begin
                    s_next     = hdr_size;
                    state_next = S_FNXA;
                end
                else
                begin
                    state_next = S_FPV;
                end
            end
            S_FNXA:
            begin
                size_next  = alu_res;
                state_next = S_FPV;
            end
            S_FPV:
            begin
                if (h_reg != '0)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = alu_res[AW-1:0];
                    state_next = S_FPVD;
                end
                else
                begin
                    state_next = S_FWR;
                end
            end
            S_FPVD:
            begin
                // The word before the block is the back header of its left neighbor.
                if (!hdr_used && (hdr_word != '0) && !alu_carry)
                begin
                    cur_next   = alu_res;
                    s_next     = hdr_word;
                    state_next = S_FPVA;
                end
                else
                begin
                    state_next = S_FWR;
                end
            end
            S_FPVA:
            begin
                size_next  = alu_res;
                state_next = S_FWR;
            end
            S_FWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg[AW-1:0];
                mem_wdata  = size_reg[DW-1:0];
                e_next     = alu_res;
                state_next = S_FWR2;
            end
            S_FWR2:
            begin
                mem_we      = 1'b1;
                mem_waddr   = alu_res[AW-1:0];
                mem_wdata   = size_reg[DW-1:0];
                done_next   = 1'b1;
                status_next = btbf_pkg::ST_OK;
                offset_next = '0;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= btbf_pkg::ST_OK;
            offset_reg <= '0;
            found_reg  <= 1'b0;
            need_reg   <= '0;
            cur_reg    <= '0;
            nxt_reg    <= '0;
            s_reg      <= '0;
            diff_reg   <= '0;
            best_reg   <= '0;
            bdiff_reg  <= '0;
            e_reg      <= '0;
            h_reg      <= '0;
            size_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            offset_reg <= offset_next;
            found_reg  <= found_next;
            need_reg   <= need_next;
            cur_reg    <= cur_next;
            nxt_reg    <= nxt_next;
            s_reg      <= s_next;
            diff_reg   <= diff_next;
            best_reg   <= best_next;
            bdiff_reg  <= bdiff_next;
            e_reg      <= e_next;
            h_reg      <= h_next;
            size_reg   <= size_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign alloc_offset = offset_reg;

`ifndef SYNTH
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither started nor answered");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while the sequencer is still busy");

    a_fail_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != btbf_pkg::ST_OK)) |-> (alloc_offset == '0))
        else $error("failed command returned a nonzero offset");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (XW'(mem_waddr) < SIZE_X))
        else $error("header write outside the arena");
`endif

endmodule

`default_nettype wire

>>> test/arena_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the allocator: shadow boundary tags, predicted replies and the compare.
module arena_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       command,
    input  logic [btbf_pkg::REQ_W-1:0] request_bytes,
    input  logic [btbf_pkg::OFF_W-1:0] free_offset,
    input  logic                       done,
    input  logic [btbf_pkg::ST_W-1:0]  status,
    input  logic [btbf_pkg::OFF_W-1:0] alloc_offset,
    output int                         mismatches,
    output int                         pending
);

    localparam int ARENA_SIZE = (btbf_pkg::ARENA_WORDS_DEF + 1) / 2 * 2;
    localparam logic [7:0] USED_MARK = 8'd1;

    typedef struct packed {
        logic [btbf_pkg::ST_W-1:0]  status;
        logic [btbf_pkg::OFF_W-1:0] offset;
    } reply_t;

    logic [7:0] tags [ARENA_SIZE];
    reply_t expected_replies [$];
    int mismatch_total = 0;
    int pending_total = 0;

    assign mismatches = mismatch_total;
    assign pending = pending_total;

    // Size of the block whose front tag sits at p; zero for a tag that would break the walk.
    function automatic int block_words(input int p);
        int s;
        s = int'(tags[p] & ~USED_MARK);
        if (s == 0 || s > ARENA_SIZE - p)
            return 0;
        return s;
    endfunction

    function automatic void stamp_block(input int front, input int size, input logic used);
        logic [7:0] v;
        v = 8'(size) | {7'd0, used};
        tags[front] = v;
        tags[front + size - 1] = v;
    endfunction

    function automatic reply_t grant_block(input int bytes);
        reply_t r;
        int need;
        int p;
        int s;
        int best;
        int best_slack;
        int old;
        bit found;
        need = (bytes + 3) / 4 + 2;
        need = (need + 1) & ~1;
        p = 0;
        best = 0;
        best_slack = 0;
        found = 1'b0;
        while (p < ARENA_SIZE)
        begin
            s = block_words(p);
            if (s == 0)
                break;
            // Strict compare keeps the first block on a tie.
            if (!tags[p][0] && s >= need && (!found || s - need < best_slack))
            begin
                found = 1'b1;
                best = p;
                best_slack = s - need;
            end
            p += s;
        end
        r.offset = '0;
        if (!found)
        begin
            r.status = btbf_pkg::ST_NO_FIT;
            return r;
        end
        old = int'(tags[best] & ~USED_MARK);
        stamp_block(best, need, 1'b1);
        if (need < old)
            stamp_block(best + need, old - need, 1'b0);
        r.status = btbf_pkg::ST_OK;
        r.offset = btbf_pkg::OFF_W'(best + 1);
        return r;
    endfunction

    function automatic reply_t release_block(input int off);
        reply_t r;
        int h;
        int p;
        int s;
        int size;
        int front;
        int nx;
        int ps;
        bit owned;
        r.status = btbf_pkg::ST_BAD_FREE;
        r.offset = '0;
        if (off == 0 || off > ARENA_SIZE)
            return r;
        h = off - 1;
        p = 0;
        owned = 1'b0;
        while (p < ARENA_SIZE && p <= h)
        begin
            s = block_words(p);
            if (s == 0)
                break;
            if (p == h)
            begin
                owned = tags[p][0];
                break;
            end
            p += s;
        end
        if (!owned)
            return r;
        size = int'(tags[h] & ~USED_MARK);
        front = h;
        nx = h + size;
        if (nx < ARENA_SIZE && !tags[nx][0])
            size += block_words(nx);
        // The back tag of the previous block tells how far back its front lies.
        if (h > 0 && !tags[h - 1][0])
        begin
            ps = int'(tags[h - 1]);
            if (ps != 0 && ps <= h)
            begin
                front = h - ps;
                size += ps;
            end
        end
        stamp_block(front, size, 1'b0);
        r.status = btbf_pkg::ST_OK;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatch_total < 10)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ARENA_SIZE; i++)
                tags[i] = '0;
            tags[0] = 8'(ARENA_SIZE);
            tags[ARENA_SIZE - 1] = 8'(ARENA_SIZE);
            expected_replies.delete();
            pending_total <= 0;
        end
        else
        begin
            // A beat's reply never lands on the edge that accepts it, so compare first.
            if (done === 1'b1)
            begin
                if (expected_replies.size() == 0)
                begin
                    note_mismatch($sformatf("reply with none pending: status %0d offset %0d",
                                            status, alloc_offset));
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.status)
                        note_mismatch($sformatf("status expected %0d got %0d",
                                                want.status, status));
                    if (alloc_offset !== want.offset)
                        note_mismatch($sformatf("alloc_offset expected %0d got %0d",
                                                want.offset, alloc_offset));
                end
            end
            if (start && busy === 1'b0)
            begin
                if (command == btbf_pkg::CMD_ALLOC)
                    want = grant_block(int'(request_bytes));
                else
                    want = release_block(int'(free_offset));
                expected_replies.push_back(want);
            end
            pending_total <= expected_replies.size();
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives allocate and free beats into the allocator and reports the verdict.
module tb;

    localparam int RANDOM_BEATS = 1625;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 250;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       command = btbf_pkg::CMD_ALLOC;
    logic [btbf_pkg::REQ_W-1:0] request_bytes = '0;
    logic [btbf_pkg::OFF_W-1:0] free_offset = '0;
    logic                       busy;
    logic                       done;
    logic [btbf_pkg::ST_W-1:0]  status;
    logic [btbf_pkg::OFF_W-1:0] alloc_offset;
    int                         mismatch_count;
    int                         pending_count;
    logic [btbf_pkg::OFF_W-1:0] granted_offsets [$];
    bit                         timed_out = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    boundary_tag_best_fit_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .request_bytes (request_bytes),
        .free_offset   (free_offset),
        .done          (done),
        .status        (status),
        .alloc_offset  (alloc_offset)
    );

    arena_checker tag_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .request_bytes (request_bytes),
        .free_offset   (free_offset),
        .done          (done),
        .status        (status),
        .alloc_offset  (alloc_offset),
        .mismatches    (mismatch_count),
        .pending       (pending_count)
    );

    // Only a granted allocate carries a nonzero offset; those become targets for later frees.
    always @(negedge clk)
    begin
        if (rst_n && done === 1'b1 && alloc_offset != '0)
            granted_offsets.push_back(alloc_offset);
    end

    task automatic issue(input logic cmd, input int value);
        command <= cmd;
        if (cmd == btbf_pkg::CMD_ALLOC)
        begin
            request_bytes <= btbf_pkg::REQ_W'(value);
            free_offset <= btbf_pkg::OFF_W'($urandom_range(0, 127));
        end
        else
        begin
            free_offset <= btbf_pkg::OFF_W'(value);
            request_bytes <= btbf_pkg::REQ_W'($urandom_range(0, 511));
        end
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic wait_for_replies();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    initial
    begin
        int burst_left;
        int gap;
        int dice;
        int idx;
        int last_freed;
        int idle_cycles;
        burst_left = 0;
        last_freed = 1;
        idle_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin
                // Oversized request, zero, one byte, an exact fill of the arena, zero again.
                issue(btbf_pkg::CMD_ALLOC, 511);
                issue(btbf_pkg::CMD_ALLOC, 0);
                issue(btbf_pkg::CMD_ALLOC, 1);
                issue(btbf_pkg::CMD_ALLOC, 480);
                issue(btbf_pkg::CMD_ALLOC, 0);
                // Bad frees: offset zero, inside a block, near the end of the arena.
                issue(btbf_pkg::CMD_FREE, 0);
                issue(btbf_pkg::CMD_FREE, 2);
                issue(btbf_pkg::CMD_FREE, 127);
                // Free, double free, then merges with the next and the previous block.
                issue(btbf_pkg::CMD_FREE, 3);
                issue(btbf_pkg::CMD_FREE, 3);
                issue(btbf_pkg::CMD_FREE, 1);
                issue(btbf_pkg::CMD_FREE, 7);
                // Leave holes of equal and unequal size to exercise the best-fit choice.
                issue(btbf_pkg::CMD_ALLOC, 20);
                issue(btbf_pkg::CMD_ALLOC, 0);
                issue(btbf_pkg::CMD_ALLOC, 4);
                issue(btbf_pkg::CMD_ALLOC, 0);
                issue(btbf_pkg::CMD_ALLOC, 20);
                issue(btbf_pkg::CMD_ALLOC, 0);
                issue(btbf_pkg::CMD_FREE, 1);
                issue(btbf_pkg::CMD_FREE, 11);
                issue(btbf_pkg::CMD_FREE, 17);
                issue(btbf_pkg::CMD_ALLOC, 4);
                issue(btbf_pkg::CMD_ALLOC, 20);
                issue(btbf_pkg::CMD_ALLOC, 12);
                wait_for_replies();

                for (int n = 0; n < RANDOM_BEATS; n++)
                begin
                    if (n > 0 && n % 400 == 0)
                    begin
                        wait_for_replies();
                    end
                    else if (burst_left <= 0)
                    begin
                        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        if (gap > 0)
                        begin
                            start <= 1'b0;
                            repeat (gap) @(posedge clk);
                        end
                        burst_left = $urandom_range(1, 30);
                    end
                    burst_left--;
                    dice = $urandom_range(0, 99);
                    if (granted_offsets.size() > 0 && dice < 45)
                    begin
                        idx = $urandom_range(0, granted_offsets.size() - 1);
                        last_freed = granted_offsets[idx];
                        granted_offsets.delete(idx);
                        issue(btbf_pkg::CMD_FREE, last_freed);
                    end
                    else if (dice >= 93)
                    begin
                        // Noise: a repeated free or an arbitrary address.
                        issue(btbf_pkg::CMD_FREE, $urandom_range(0, 1) ? last_freed
                                                                       : $urandom_range(0, 127));
                    end
                    else
                    begin
                        dice = $urandom_range(0, 9);
                        issue(btbf_pkg::CMD_ALLOC, (dice < 7) ? $urandom_range(0, 40) :
                                                   (dice < 9) ? $urandom_range(0, 160) :
                                                                $urandom_range(0, 511));
                    end
                end
                wait_for_replies();
                repeat (SETTLE_CYCLES) @(posedge clk);
            end
            begin
                while (idle_cycles < IDLE_LIMIT)
                begin
                    @(posedge clk);
                    if ((start && busy === 1'b0) || done === 1'b1)
                        idle_cycles = 0;
                    else
                        idle_cycles++;
                end
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && mismatch_count == 0 && pending_count == 0)
            $display("boundary_tag_best_fit_allocator regression: pass");
        else
            $display("boundary_tag_best_fit_allocator regression: fail");
        $finish;
    end

endmodule
